// ----- rtl/vbc_pkg.sv -----
// Shared types, constants and codes of the ventilator breath controller.
`timescale 1ns / 1ps
package vbc_pkg;

    // Fixed-point fraction bits of setpoints, targets and slopes.
    localparam int FRAC_BITS_DEF = 16;

    localparam int SEC_PER_MIN  = 60;
    localparam int MS_PER_SEC   = 1000;
    localparam int PHASE_PARTS  = 3;
    localparam int INHALE_MS_NUM = SEC_PER_MIN * MS_PER_SEC / PHASE_PARTS;
    localparam int EXHALE_MS_NUM = 2 * SEC_PER_MIN * MS_PER_SEC / PHASE_PARTS;

    localparam int LEN_W  = 16;
    localparam int ERR_W  = 18;
    localparam int VOL_W  = 24;
    localparam int CNT_W  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_RATE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_TGT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_TGT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TANK_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TANK_HIGH = 3'd6;

    localparam logic [7:0]  RATE_RST      = 8'd85;
    localparam logic [9:0]  VOL_TGT_RST   = 10'd750;
    localparam logic [11:0] PRES_TGT_RST  = 12'd0;
    localparam logic [14:0] TANK_LOW_RST  = 15'd9000;
    localparam logic [14:0] TANK_HIGH_RST = 15'd10000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_IN,
        PH_OUT
    } phase_t;

    typedef enum logic [3:0] {
        ST_WAIT_IN,
        ST_LEN_GO,
        ST_LEN_WAIT,
        ST_EVAL,
        ST_TLEN_GO,
        ST_TLEN_WAIT,
        ST_AIR_GO,
        ST_AIR_WAIT,
        ST_PSL_GO,
        ST_PSL_WAIT,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        DOP_LEN_IN,
        DOP_LEN_OUT,
        DOP_AIR_IN,
        DOP_P_IN,
        DOP_AIR_OUT,
        DOP_P_OUT
    } div_op_t;

    typedef struct packed {
        logic    capture;
        logic    div_start;
        logic    div_wait;
        div_op_t div_op;
        logic    eval;
        logic    push;
    } cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   exhale_start;
        logic   begin_breath;
        logic   div_done;
        logic   out_free;
    } status_t;

    typedef struct packed {
        logic [7:0]         dt_ms;
        logic signed [15:0] chamber_pressure;
        logic signed [15:0] tank_pressure;
        logic signed [15:0] flow_increment;
        logic               stop_request;
    } in_word_t;

    typedef struct packed {
        logic               vacuum_valve;
        logic               outlet_valve;
        logic               bridge_drive;
        logic               pump_on;
        logic               inhaling;
        logic signed [15:0] setpoint_pressure;
        logic [15:0]        breath_number;
        logic               halted;
    } out_word_t;

endpackage

// ----- rtl/vbc_if.sv -----
// Valid/ready channel interfaces for sample words and result words.
`timescale 1ns / 1ps
interface vbc_in_if;
    logic             valid;
    logic             ready;
    vbc_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vbc_out_if;
    logic              valid;
    logic              ready;
    vbc_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/vbc_divider.sv -----
// Radix-2 restoring signed-by-unsigned divider, quotient truncated toward zero.
`timescale 1ns / 1ps
module vbc_divider #(
    parameter int DW = 38,
    parameter int LW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic [LW-1:0]        divisor,
    output logic                 busy,
    output logic                 done,
    output logic signed [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic [LW-1:0] dvs_reg, dvs_next;
    logic signed [DW-1:0] res_reg, res_next;
    logic [LW:0]   trial;
    logic [LW:0]   shifted;
    logic          fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        trial     = shifted - {1'b0, dvs_reg};
        fits      = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            neg_next  = dividend[DW-1];
            quo_next  = dividend[DW-1] ? DW'(-dividend) : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[LW-1:0] : shifted[LW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? -$signed(quo_next) : $signed(quo_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        res_reg <= res_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = res_reg;
endmodule

// ----- rtl/vbc_ctrl.sv -----
// Sequencer for one sample word: phase length, update, phase-start slopes, result.
`timescale 1ns / 1ps
module vbc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  vbc_pkg::status_t status,
    output vbc_pkg::cmd_t    cmd
);
    import vbc_pkg::*;

    state_t state_reg, state_next;
    logic   kind_reg, kind_next;   // 1: exhale start, 0: breath start

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            ST_WAIT_IN:
                if (in_valid)
                    state_next = (status.phase == PH_IDLE) ? ST_EVAL : ST_LEN_GO;
            ST_LEN_GO:    state_next = ST_LEN_WAIT;
            ST_LEN_WAIT:  if (status.div_done) state_next = ST_EVAL;
            ST_EVAL:
            begin
                kind_next = status.exhale_start;
                if (status.exhale_start || status.begin_breath)
                    state_next = ST_TLEN_GO;
                else
                    state_next = ST_RESULT;
            end
            ST_TLEN_GO:   state_next = ST_TLEN_WAIT;
            ST_TLEN_WAIT: if (status.div_done) state_next = ST_AIR_GO;
            ST_AIR_GO:    state_next = ST_AIR_WAIT;
            ST_AIR_WAIT:  if (status.div_done) state_next = ST_PSL_GO;
            ST_PSL_GO:    state_next = ST_PSL_WAIT;
            ST_PSL_WAIT:  if (status.div_done) state_next = ST_RESULT;
            ST_RESULT:    if (status.out_free) state_next = ST_WAIT_IN;
            default:      state_next = ST_WAIT_IN;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_WAIT_IN);
        cmd.capture   = (state_reg == ST_WAIT_IN) && in_valid;
        cmd.div_start = 1'b0;
        cmd.div_wait  = 1'b0;
        cmd.div_op    = DOP_LEN_IN;
        cmd.eval      = (state_reg == ST_EVAL);
        cmd.push      = (state_reg == ST_RESULT) && status.out_free;
        unique case (state_reg)
            ST_LEN_GO, ST_LEN_WAIT:
            begin
                cmd.div_start = (state_reg == ST_LEN_GO);
                cmd.div_wait  = (state_reg == ST_LEN_WAIT);
                cmd.div_op    = (status.phase == PH_IN) ? DOP_LEN_IN : DOP_LEN_OUT;
            end
            ST_TLEN_GO, ST_TLEN_WAIT:
            begin
                cmd.div_start = (state_reg == ST_TLEN_GO);
                cmd.div_wait  = (state_reg == ST_TLEN_WAIT);
                cmd.div_op    = kind_reg ? DOP_LEN_OUT : DOP_LEN_IN;
            end
            ST_AIR_GO, ST_AIR_WAIT:
            begin
                cmd.div_start = (state_reg == ST_AIR_GO);
                cmd.div_wait  = (state_reg == ST_AIR_WAIT);
                cmd.div_op    = kind_reg ? DOP_AIR_OUT : DOP_AIR_IN;
            end
            ST_PSL_GO, ST_PSL_WAIT:
            begin
                cmd.div_start = (state_reg == ST_PSL_GO);
                cmd.div_wait  = (state_reg == ST_PSL_WAIT);
                cmd.div_op    = kind_reg ? DOP_P_OUT : DOP_P_IN;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT_IN;
            kind_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end
endmodule

// ----- rtl/vbc_datapath.sv -----
// Breath state, ramps, valve decisions, configuration registers and output word.
`timescale 1ns / 1ps
module vbc_datapath #(
    parameter int FRAC_BITS = vbc_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  vbc_pkg::cmd_t                      cmd,
    output vbc_pkg::status_t                   status,
    input  vbc_pkg::in_word_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output vbc_pkg::out_word_t                 out_data,
    input  logic                               cfg_we,
    input  logic [vbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vbc_pkg::*;

    localparam int SW = 16 + FRAC_BITS;    // setpoint
    localparam int DW = FRAC_BITS + 22;    // slopes, air target, divider
    localparam int PW = DW + 9;            // slope times dt
    localparam int XW = PW + 1;            // ramp sums
    localparam logic signed [XW-1:0] SP_MAX_X = XW'({1'b0, {(SW-1){1'b1}}});
    localparam logic signed [XW-1:0] SP_MIN_X = -SP_MAX_X - XW'(1);

    // Configuration registers.
    logic [7:0]  rate_reg;
    logic [9:0]  vol_tgt_reg;
    logic [11:0] pres_tgt_reg;
    logic        vol_mode_reg;
    logic        enable_reg, enable_next;
    logic [14:0] tank_low_reg;
    logic [14:0] tank_high_reg;

    // Breath state.
    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   elapsed_reg, elapsed_next;
    logic signed [SW-1:0] sp_reg, sp_next;
    logic signed [DW-1:0] air_reg, air_next;
    logic [VOL_W-1:0]   del_reg, del_next;
    logic signed [DW-1:0] p_slope_reg;
    logic signed [DW-1:0] a_slope_reg;
    logic signed [ERR_W-1:0] ie_reg, ie_next;
    logic signed [ERR_W-1:0] ee_reg, ee_next;
    logic               pump_reg, pump_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               halt_reg, halt_next;
    logic [LEN_W-1:0]   len_reg;

    in_word_t  in_reg;
    out_word_t res_reg, res_next;
    out_word_t out_reg;
    logic      out_valid_reg;
    logic signed [PW-1:0] p_prod_reg;
    logic signed [PW-1:0] a_prod_reg;

    // Divider.
    logic signed [DW-1:0] div_num;
    logic [LEN_W-1:0]     div_den;
    logic                 div_busy;
    logic                 div_done;
    logic signed [DW-1:0] div_quo;

    // Update terms.
    logic signed [15:0]   ch;
    logic signed [SW-1:0] ch_sh;
    logic [LEN_W:0]       el_sum;
    logic [LEN_W-1:0]     el_sat;
    logic                 past_end;
    logic                 boundary;
    logic                 vac;
    logic                 outlet;
    logic signed [XW-1:0] sp_x;
    logic signed [XW-1:0] sp_ramp;
    logic signed [XW-1:0] sp_clamped;
    logic signed [XW-1:0] sp_lim;
    logic signed [XW-1:0] air_ramp;
    logic signed [XW-1:0] del_sh;
    logic [VOL_W:0]       del_sum;
    logic [VOL_W-1:0]     del_acc;
    logic signed [15:0]   sp_floor;
    logic [7:0]           rate_eff;

    vbc_divider #(
        .DW (DW),
        .LW (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign ch       = in_reg.chamber_pressure;
    assign ch_sh    = $signed({ch, {FRAC_BITS{1'b0}}});
    assign sp_floor = $signed(sp_reg[SW-1:FRAC_BITS]);
    assign rate_eff = (rate_reg == 8'd0) ? 8'd1 : rate_reg;

    always_comb
    begin
        unique case (cmd.div_op)
            DOP_LEN_IN:  div_num = DW'(INHALE_MS_NUM);
            DOP_LEN_OUT: div_num = DW'(EXHALE_MS_NUM);
            DOP_AIR_IN:  div_num = $signed(DW'({vol_tgt_reg, {FRAC_BITS{1'b0}}}));
            DOP_P_IN:    div_num = (DW'($signed({1'b0, pres_tgt_reg})) + DW'(ie_reg))
                                   <<< FRAC_BITS;
            DOP_AIR_OUT: div_num = air_reg;
            DOP_P_OUT:   div_num = (DW'(ch) + DW'(ee_reg)) <<< FRAC_BITS;
            default:     div_num = '0;
        endcase
        if (cmd.div_op == DOP_LEN_IN || cmd.div_op == DOP_LEN_OUT)
            div_den = LEN_W'(rate_eff);
        else
            div_den = len_reg;
    end

    // Ramp steps and sample-tick update.
    always_comb
    begin
        el_sum   = {1'b0, elapsed_reg} + (LEN_W + 1)'(in_reg.dt_ms);
        el_sat   = el_sum[LEN_W] ? {LEN_W{1'b1}} : el_sum[LEN_W-1:0];
        past_end = (el_sat > len_reg);
        del_sum  = {1'b0, del_reg} + (VOL_W + 1)'(in_reg.flow_increment[14:0]);
        del_acc  = del_sum[VOL_W] ? {VOL_W{1'b1}} : del_sum[VOL_W-1:0];
        sp_x     = XW'(sp_reg);
        sp_lim   = (XW'($signed({1'b0, pres_tgt_reg})) + XW'(ee_reg)) <<< FRAC_BITS;
        if (phase_reg == PH_IN)
            sp_ramp = sp_x + XW'(p_prod_reg);
        else
            sp_ramp = sp_x - XW'(p_prod_reg);
        if (sp_ramp > SP_MAX_X)
            sp_clamped = SP_MAX_X;
        else if (sp_ramp < SP_MIN_X)
            sp_clamped = SP_MIN_X;
        else
            sp_clamped = sp_ramp;
        if (phase_reg == PH_IN)
            air_ramp = XW'(air_reg) + XW'(a_prod_reg);
        else
            air_ramp = XW'(air_reg) - XW'(a_prod_reg);

        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        sp_next      = sp_reg;
        air_next     = air_reg;
        del_next     = del_reg;
        ie_next      = ie_reg;
        ee_next      = ee_reg;
        pump_next    = pump_reg;
        count_next   = count_reg;
        halt_next    = halt_reg;
        enable_next  = enable_reg;
        boundary     = 1'b0;
        vac          = 1'b0;
        outlet       = 1'b1;
        del_sh       = '0;

        unique case (phase_reg)
            PH_IN:
            begin
                elapsed_next = el_sat;
                if (!in_reg.flow_increment[15] && in_reg.flow_increment != 16'sd0)
                    del_next = del_acc;
                if (!past_end)
                begin
                    air_next = DW'(air_ramp);
                    if (sp_x <= sp_lim)
                        sp_next = SW'(sp_clamped);
                    del_sh = $signed(XW'({del_next, {FRAC_BITS{1'b0}}}));
                    if (vol_mode_reg)
                        vac = (del_sh <= XW'(air_next));
                    else
                        vac = (XW'(ch_sh) <= XW'(sp_next));
                    outlet = 1'b0;
                end
                else
                begin
                    // Exhale begins from the measured chamber pressure.
                    ie_next      = ERR_W'($signed({1'b0, pres_tgt_reg})) - ERR_W'(ch);
                    phase_next   = PH_OUT;
                    elapsed_next = '0;
                    sp_next      = ch_sh;
                    vac          = 1'b0;
                    outlet       = 1'b1;
                end
            end
            PH_OUT:
            begin
                elapsed_next = el_sat;
                if (!past_end)
                begin
                    air_next = air_ramp[XW-1] ? '0 : DW'(air_ramp);
                    if (sp_reg > 0)
                        sp_next = SW'(sp_clamped);
                    outlet = (ch_sh >= sp_next);
                end
                else
                begin
                    ee_next      = ERR_W'(ch) - ERR_W'(sp_floor);
                    del_next     = '0;
                    phase_next   = PH_IDLE;
                    elapsed_next = '0;
                    boundary     = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                boundary   = 1'b1;
            end
        endcase

        if (boundary)
        begin
            if (in_reg.stop_request)
            begin
                halt_next   = 1'b1;
                enable_next = 1'b0;
                pump_next   = 1'b0;
                vac         = 1'b0;
                outlet      = 1'b1;
            end
            else if (enable_reg)
            begin
                count_next   = count_reg + CNT_W'(1);
                del_next     = '0;
                air_next     = '0;
                sp_next      = ch_sh;
                elapsed_next = '0;
                phase_next   = PH_IN;
                // Setpoint equals chamber and both volumes are zero, so the valve opens.
                vac          = 1'b1;
                outlet       = 1'b0;
            end
            else
            begin
                vac    = 1'b0;
                outlet = 1'b1;
            end
        end

        if (in_reg.tank_pressure <= $signed({1'b0, tank_low_reg}))
            pump_next = 1'b1;
        if (in_reg.tank_pressure >= $signed({1'b0, tank_high_reg}))
            pump_next = 1'b0;

        res_next.vacuum_valve      = vac;
        res_next.outlet_valve      = outlet;
        res_next.bridge_drive      = (phase_next == PH_IN);
        res_next.pump_on           = pump_next;
        res_next.inhaling          = (phase_next == PH_IN);
        res_next.setpoint_pressure = $signed(sp_next[SW-1:FRAC_BITS]);
        res_next.breath_number     = count_next;
        res_next.halted            = halt_next;
    end

    always_comb
    begin
        status.phase        = phase_reg;
        status.exhale_start = (phase_reg == PH_IN) && past_end;
        status.begin_breath = ((phase_reg == PH_IDLE) || ((phase_reg == PH_OUT) && past_end))
                              && !in_reg.stop_request && enable_reg;
        status.div_done     = div_done;
        status.out_free     = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= RATE_RST;
            vol_tgt_reg   <= VOL_TGT_RST;
            pres_tgt_reg  <= PRES_TGT_RST;
            vol_mode_reg  <= 1'b0;
            enable_reg    <= 1'b0;
            tank_low_reg  <= TANK_LOW_RST;
            tank_high_reg <= TANK_HIGH_RST;
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            sp_reg        <= '0;
            air_reg       <= '0;
            del_reg       <= '0;
            p_slope_reg   <= '0;
            a_slope_reg   <= '0;
            ie_reg        <= '0;
            ee_reg        <= '0;
            pump_reg      <= 1'b1;
            count_reg     <= '0;
            halt_reg      <= 1'b0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RATE:      rate_reg      <= cfg_data[7:0];
                    REG_VOL_TGT:   vol_tgt_reg   <= cfg_data[9:0];
                    REG_PRES_TGT:  pres_tgt_reg  <= cfg_data[11:0];
                    REG_VOL_MODE:  vol_mode_reg  <= cfg_data[0];
                    REG_ENABLE:
                    begin
                        enable_reg <= cfg_data[0];
                        halt_reg   <= 1'b0;
                    end
                    REG_TANK_LOW:  tank_low_reg  <= cfg_data[14:0];
                    REG_TANK_HIGH: tank_high_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
            else if (cmd.eval)
            begin
                enable_reg <= enable_next;
                halt_reg   <= halt_next;
            end
            if (cmd.eval)
            begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
                sp_reg      <= sp_next;
                air_reg     <= air_next;
                del_reg     <= del_next;
                ie_reg      <= ie_next;
                ee_reg      <= ee_next;
                pump_reg    <= pump_next;
                count_reg   <= count_next;
            end
            if (cmd.div_wait && div_done)
            begin
                unique case (cmd.div_op)
                    DOP_LEN_IN, DOP_LEN_OUT: len_reg     <= div_quo[LEN_W-1:0];
                    DOP_AIR_IN, DOP_AIR_OUT: a_slope_reg <= div_quo;
                    DOP_P_IN, DOP_P_OUT:     p_slope_reg <= div_quo;
                    default: ;
                endcase
            end
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= in_data;
        if (cmd.eval)
            res_reg <= res_next;
        if (cmd.push)
            out_reg <= res_reg;
        // Ramp steps are ready well before the update; slopes and dt hold meanwhile.
        p_prod_reg <= p_slope_reg * $signed({1'b0, in_reg.dt_ms});
        a_prod_reg <= a_slope_reg * $signed({1'b0, in_reg.dt_ms});
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_halt_idle : assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> phase_reg == PH_IDLE)
        else $error("halted while a breath is running");

    a_idle_no_volume : assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> del_reg == '0)
        else $error("delivered volume left over outside a breath");

    a_div_free : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_push_after_eval : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |=> !cmd.eval)
        else $error("update applied twice for one word");
`endif
endmodule

// ----- rtl/ventilator_breath_controller_top.sv -----
// Top level of the ventilator breath controller: sequencer, datapath and ports.
// Flow: an idle tick is captured, evaluated and queued as a result word; during a phase the
// phase length is first divided out, and a phase start adds three serial divisions (next
// phase length, air slope, pressure slope) before the result word.
// One word is processed at a time; the next input word is taken while a result waits.
// Reset (rst_n, asynchronous, active low) gives idle phase, pump on, registers at defaults.
`timescale 1ns / 1ps
module ventilator_breath_controller_top #(
    parameter int FRAC_BITS = vbc_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    vbc_in_if.sink                             in_ch,
    vbc_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [vbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vbc_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    vbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    vbc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign in_ch.ready = in_ready;
endmodule

// ----- bench/tb_ventilator_breath_controller_top.sv -----
// Self-checking testbench for the ventilator breath controller top level.
`timescale 1ns / 1ps
module tb_ventilator_breath_controller_top;
    import vbc_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint FX_ONE = longint'(1) << FRAC;
    localparam longint SP_HI = 64'sd32767 * FX_ONE + (FX_ONE - 1);
    localparam longint SP_LO = -64'sd32768 * FX_ONE;
    localparam longint VOL_SAT = 64'hFFFFFF;
    localparam int SETTLE_CYCLES = 4 * (FRAC + 24) + 100;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vbc_in_if in_if ();
    vbc_out_if out_if ();

    ventilator_breath_controller_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_if),
        .out_ch   (out_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Register copies held by the predictor.
    longint rate_reg, vol_tgt_reg, pres_tgt_reg, tank_low_reg, tank_high_reg;
    logic vol_mode_reg, enable_reg;

    // Predicted controller state.
    phase_t cur_phase;
    longint elapsed_ms, setpoint_fx, air_fx, p_slope_fx, a_slope_fx;
    longint delivered, in_err, ex_err;
    logic pump_reg, halt_reg;
    logic [15:0] breath_cnt;

    out_word_t expected_words[$];
    int mismatches;
    int words_sent;
    int words_checked;
    int stops_sent;
    int breaths_seen;
    int rx_mode;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint clamp_sp(longint v);
        if (v > SP_HI)
            return SP_HI;
        if (v < SP_LO)
            return SP_LO;
        return v;
    endfunction

    function automatic longint inhale_ms();
        longint r;
        r = (rate_reg == 0) ? 1 : rate_reg;
        return longint'(INHALE_MS_NUM) / r;
    endfunction

    function automatic longint exhale_ms();
        longint r;
        r = (rate_reg == 0) ? 1 : rate_reg;
        return longint'(EXHALE_MS_NUM) / r;
    endfunction

    function automatic logic vacuum_demand(longint chamber);
        if (vol_mode_reg)
            return (delivered * FX_ONE <= air_fx);
        return (chamber * FX_ONE <= setpoint_fx);
    endfunction

    task automatic reset_model();
        rate_reg = RATE_RST;
        vol_tgt_reg = VOL_TGT_RST;
        pres_tgt_reg = PRES_TGT_RST;
        vol_mode_reg = 1'b0;
        enable_reg = 1'b0;
        tank_low_reg = TANK_LOW_RST;
        tank_high_reg = TANK_HIGH_RST;
        cur_phase = PH_IDLE;
        elapsed_ms = 0;
        setpoint_fx = 0;
        air_fx = 0;
        p_slope_fx = 0;
        a_slope_fx = 0;
        delivered = 0;
        in_err = 0;
        ex_err = 0;
        pump_reg = 1'b1;
        breath_cnt = '0;
        halt_reg = 1'b0;
    endtask

    // Works out the result word of one sample tick and advances the state.
    function automatic out_word_t breath_tick(in_word_t w);
        longint dt, chamber, tank, flow, t;
        logic vac, outlet, boundary;
        out_word_t r;
        dt = w.dt_ms;
        chamber = w.chamber_pressure;
        tank = w.tank_pressure;
        flow = w.flow_increment;
        vac = 1'b0;
        outlet = 1'b1;
        boundary = 1'b0;
        if (cur_phase == PH_IN)
        begin
            elapsed_ms = elapsed_ms + dt;
            if (elapsed_ms > 65535)
                elapsed_ms = 65535;
            if (flow > 0)
            begin
                delivered = delivered + flow;
                if (delivered > VOL_SAT)
                    delivered = VOL_SAT;
            end
            if (elapsed_ms <= inhale_ms())
            begin
                air_fx = air_fx + a_slope_fx * dt;
                if (setpoint_fx <= (pres_tgt_reg + ex_err) * FX_ONE)
                    setpoint_fx = clamp_sp(setpoint_fx + p_slope_fx * dt);
                vac = vacuum_demand(chamber);
                outlet = 1'b0;
            end
            else
            begin
                t = exhale_ms();
                in_err = pres_tgt_reg - chamber;
                cur_phase = PH_OUT;
                elapsed_ms = 0;
                a_slope_fx = air_fx / t;
                p_slope_fx = (chamber + ex_err) * FX_ONE / t;
                setpoint_fx = clamp_sp(chamber * FX_ONE);
                vac = 1'b0;
                outlet = (chamber * FX_ONE >= setpoint_fx);
            end
        end
        else if (cur_phase == PH_OUT)
        begin
            elapsed_ms = elapsed_ms + dt;
            if (elapsed_ms > 65535)
                elapsed_ms = 65535;
            if (elapsed_ms <= exhale_ms())
            begin
                air_fx = air_fx - a_slope_fx * dt;
                if (air_fx < 0)
                    air_fx = 0;
                if (setpoint_fx > 0)
                    setpoint_fx = clamp_sp(setpoint_fx - p_slope_fx * dt);
                outlet = (chamber * FX_ONE >= setpoint_fx);
            end
            else
            begin
                ex_err = chamber - (setpoint_fx >>> FRAC);
                delivered = 0;
                cur_phase = PH_IDLE;
                elapsed_ms = 0;
                boundary = 1'b1;
            end
        end
        else
        begin
            boundary = 1'b1;
        end

        if (boundary)
        begin
            if (w.stop_request)
            begin
                halt_reg = 1'b1;
                enable_reg = 1'b0;
                pump_reg = 1'b0;
                vac = 1'b0;
                outlet = 1'b1;
            end
            else if (enable_reg)
            begin
                // The flow of the starting tick is dropped and the ramp stays put.
                t = inhale_ms();
                breath_cnt = breath_cnt + 16'd1;
                breaths_seen++;
                delivered = 0;
                air_fx = 0;
                setpoint_fx = clamp_sp(chamber * FX_ONE);
                elapsed_ms = 0;
                cur_phase = PH_IN;
                a_slope_fx = vol_tgt_reg * FX_ONE / t;
                p_slope_fx = (pres_tgt_reg + in_err) * FX_ONE / t;
                vac = vacuum_demand(chamber);
                outlet = 1'b0;
            end
        end

        if (tank <= tank_low_reg)
            pump_reg = 1'b1;
        if (tank >= tank_high_reg)
            pump_reg = 1'b0;

        r.vacuum_valve = vac;
        r.outlet_valve = outlet;
        r.bridge_drive = (cur_phase == PH_IN);
        r.pump_on = pump_reg;
        r.inhaling = (cur_phase == PH_IN);
        r.setpoint_pressure = 16'(setpoint_fx >>> FRAC);
        r.breath_number = breath_cnt;
        r.halted = halt_reg;
        return r;
    endfunction

    task automatic send_word(in_word_t w);
        in_if.valid <= 1'b1;
        in_if.data <= w;
        do
            @(posedge clk);
        while (!in_if.ready);
        expected_words.push_back(breath_tick(w));
        words_sent++;
        if (w.stop_request)
            stops_sent++;
    endtask

    task automatic idle_sender(int cycles);
        in_if.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Waits for every predicted word, then lets a late phase-start division finish.
    task automatic drain();
        idle_sender(1);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_RATE: rate_reg = value & 8'hFF;
            REG_VOL_TGT: vol_tgt_reg = value & 10'h3FF;
            REG_PRES_TGT: pres_tgt_reg = value & 12'hFFF;
            REG_VOL_MODE: vol_mode_reg = value[0];
            REG_ENABLE:
            begin
                enable_reg = value[0];
                halt_reg = 1'b0;
            end
            REG_TANK_LOW: tank_low_reg = value & 15'h7FFF;
            REG_TANK_HIGH: tank_high_reg = value & 15'h7FFF;
            default: ;
        endcase
    endtask

    task automatic setup(longint rate, longint vtgt, longint ptgt, logic vmode,
                         longint tlow, longint thigh);
        drain();
        write_reg(REG_RATE, rate);
        write_reg(REG_VOL_TGT, vtgt);
        write_reg(REG_PRES_TGT, ptgt);
        write_reg(REG_VOL_MODE, vmode);
        write_reg(REG_TANK_LOW, tlow);
        write_reg(REG_TANK_HIGH, thigh);
        write_reg(REG_ENABLE, 1);
    endtask

    function automatic in_word_t make_word(in_word_t base, int dt, int chamber,
                                           int tank, int flow, logic stop);
        base.dt_ms = 8'(dt);
        base.chamber_pressure = 16'(chamber);
        base.tank_pressure = 16'(tank);
        base.flow_increment = 16'(flow);
        base.stop_request = stop;
        return base;
    endfunction

    function automatic in_word_t random_word(bit big_dt);
        in_word_t w;
        int sel;
        w = '0;
        sel = $urandom_range(99);
        if (big_dt)
            w.dt_ms = 8'($urandom_range(150, 255));
        else if (sel < 70)
            w.dt_ms = 8'($urandom_range(5, 40));
        else if (sel < 95)
            w.dt_ms = 8'($urandom);
        else
            w.dt_ms = '0;
        if ($urandom_range(9) < 8)
            w.chamber_pressure = 16'($urandom_range(5000) - 1000);
        else
            w.chamber_pressure = 16'($urandom);
        if ($urandom_range(9) < 8)
            w.tank_pressure = 16'($urandom_range(8000, 11000));
        else
            w.tank_pressure = 16'($urandom);
        if ($urandom_range(9) < 8)
            w.flow_increment = 16'($urandom_range(300));
        else
            w.flow_increment = 16'($urandom);
        w.stop_request = ($urandom_range(149) == 0);
        return w;
    endfunction

    // Sends bursts of random ticks; enable is restored at idle after a stop.
    task automatic random_ticks(int count, bit big_dt);
        int burst;
        int done;
        done = 0;
        while (done < count)
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && done < count)
            begin
                send_word(random_word(big_dt));
                burst--;
                done++;
            end
            if ($urandom_range(3) != 0)
                idle_sender($urandom_range(1, 120));
            if (!enable_reg && cur_phase == PH_IDLE)
            begin
                drain();
                write_reg(REG_ENABLE, 1);
            end
        end
    endtask

    task automatic test_directed();
        in_word_t w;
        w = '0;
        // Idle ticks at the field extremes; the pump sees both thresholds.
        send_word(make_word(w, 0, -32768, -32768, -32768, 0));
        send_word(make_word(w, 255, 32767, 32767, 32767, 0));
        send_word(make_word(w, 1, 0, 9000, 0, 0));
        send_word(make_word(w, 1, 0, 10000, 0, 0));
        // A stop while idle halts and forces the pump off.
        send_word(make_word(w, 10, 100, 9500, 5, 1));
        send_word(make_word(w, 10, 100, 9500, 5, 0));
        drain();
        write_reg(REG_PRES_TGT, 2999);
        write_reg(REG_ENABLE, 1);
        // Breath start, inhale ramp, flow of both signs, then the phase ends.
        send_word(make_word(w, 20, -500, 9500, 200, 0));
        send_word(make_word(w, 20, -500, 9500, 32767, 0));
        send_word(make_word(w, 50, 32767, 9500, -32768, 0));
        send_word(make_word(w, 100, -32768, 9500, 100, 1));
        send_word(make_word(w, 255, 1000, 9500, 100, 0));
        send_word(make_word(w, 100, 2000, 9500, 0, 0));
        send_word(make_word(w, 255, -32768, 9500, 0, 0));
        send_word(make_word(w, 255, 0, 9500, 0, 0));
        // A stop request at the inhale end is no breath boundary and does not halt.
        send_word(make_word(w, 255, 300, 9500, 0, 1));
        send_word(make_word(w, 10, 300, 9500, 0, 0));
        drain();
        write_reg(REG_VOL_MODE, 1);
        write_reg(REG_ENABLE, 1);
        send_word(make_word(w, 5, 0, 9500, 0, 0));
        send_word(make_word(w, 5, 0, 9500, 10, 0));
        send_word(make_word(w, 200, 0, 9500, 32767, 0));
        send_word(make_word(w, 255, 0, 9500, 0, 0));
        send_word(make_word(w, 0, 0, 9500, 0, 0));
        drain();
    endtask

    task automatic test_pressure_control();
        setup(85, 750, 1500, 1'b0, 9000, 10000);
        random_ticks(200, 1'b0);
        setup(199, 999, 2999, 1'b0, 32767, 0);
        random_ticks(150, 1'b0);
    endtask

    task automatic test_volume_control();
        setup(31, 0, 0, 1'b1, 0, 32767);
        random_ticks(200, 1'b0);
        setup(120, 500, 800, 1'b1, 9500, 9500);
        random_ticks(150, 1'b0);
    endtask

    task automatic test_rate_extremes();
        setup(255, 999, 2999, 1'b0, 9000, 10000);
        random_ticks(120, 1'b0);
        setup(0, 300, 100, 1'b1, 9000, 10000);
        random_ticks(110, 1'b1);
    endtask

    task automatic test_live_stop();
        setup(150, 750, 1000, 1'b0, 9000, 10000);
        random_ticks(80, 1'b0);
        drain();
        write_reg(REG_ENABLE, 0);
        random_ticks(20, 1'b0);
        drain();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_if.ready <= 1'b0;
        else if (rx_mode == 0)
            out_if.ready <= 1'b1;
        else if (rx_mode == 1)
            out_if.ready <= ($urandom_range(1) == 1);
        else
            out_if.ready <= ($urandom_range(15) == 0);
        if ($urandom_range(299) == 0)
            rx_mode <= $urandom_range(2);
    end

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        out_word_t e;
        out_word_t a;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            a = out_if.data;
            if (expected_words.size() == 0)
            begin
                $error("result word arrived with nothing expected");
                mismatches++;
            end
            else
            begin
                e = expected_words.pop_front();
                words_checked++;
                check_field("vacuum_valve", e.vacuum_valve, a.vacuum_valve);
                check_field("outlet_valve", e.outlet_valve, a.outlet_valve);
                check_field("bridge_drive", e.bridge_drive, a.bridge_drive);
                check_field("pump_on", e.pump_on, a.pump_on);
                check_field("inhaling", e.inhaling, a.inhaling);
                check_field("setpoint_pressure", e.setpoint_pressure,
                            a.setpoint_pressure);
                check_field("breath_number", e.breath_number, a.breath_number);
                check_field("halted", e.halted, a.halted);
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("ventilator_breath_controller_top: mismatch");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        stops_sent = 0;
        breaths_seen = 0;
        rx_mode = 0;
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pressure_control();
        test_volume_control();
        test_rate_extremes();
        test_live_stop();

        drain();
        $display("Sent %0d sample words (%0d with stop), checked %0d results.",
                 words_sent, stops_sent, words_checked);
        $display("Breaths started: %0d over pressure, volume and rate extremes.",
                 breaths_seen);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("ventilator_breath_controller_top: match");
        else
            $display("ventilator_breath_controller_top: mismatch");
        $finish;
    end
endmodule
